// File: hdl/amxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Archive member XOR decrypt: shared definitions
// Field widths, register indexes and the step control bundle used by the
// top level and the cipher stage.
// ----------------------------------------------------------------------------
package amxd_pkg;

    // Field and key widths
    localparam int BYTE_W       = 8;
    localparam int KEY_WORD_W   = 32;
    localparam int KEY_WORDS    = 4;
    localparam int KEY_BYTES    = KEY_WORDS * KEY_WORD_W / BYTE_W;
    localparam int KEY_W        = KEY_WORDS * KEY_WORD_W;
    localparam int POS_W        = $clog2(KEY_BYTES);
    localparam int FB_DEPTH     = 4;
    localparam int SLOT_W       = $clog2(FB_DEPTH);
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = KEY_WORD_W;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CIPHER_MODE = 3'd0,
        REG_KEY_WORD0   = 3'd1,
        REG_KEY_WORD1   = 3'd2,
        REG_KEY_WORD2   = 3'd3,
        REG_KEY_WORD3   = 3'd4
    } t_cfg_index;

    // Cipher modes
    typedef enum logic {
        MODE_PLAIN_XOR = 1'b0,
        MODE_FEEDBACK  = 1'b1
    } t_cipher_mode;

    // Control for one decrypt step
    typedef struct packed {
        logic advance;    // an item moves into the result register
        logic first;      // the item opens a new member
    } t_step_ctl;

endpackage

// File: hdl/archive_member_xor_decrypt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Archive member XOR decrypt core
// Decrypts an archive member one byte per item under a 16-byte key, with
// optional four-byte ciphertext feedback.
// ----------------------------------------------------------------------------
// The core takes one item per clock while the result side is not stalled, and
// returns one plain byte per item: an input register feeds the cipher stage,
// whose XOR and feedback update land in the result register. Both stages
// advance together whenever the result register is empty or being taken, so
// the sustained rate is one item per cycle. Set tuser[0] on the first byte of
// each member to restart the key position and reload the feedback store from
// key word 0. Write the mode and key only while no items are in flight.
// ----------------------------------------------------------------------------
module archive_member_xor_decrypt_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [amxd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [amxd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input items
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] cipher_byte
    input  logic [0:0]                       i_s_axis_tuser,  // [0] first_byte
    // Result items
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata   // [7:0] plain_byte
);
    import amxd_pkg::*;

    t_cipher_mode      r_mode;
    logic [KEY_W-1:0]  r_key;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              out_free;
    logic              s_accept;
    logic [BYTE_W-1:0] plain_byte;
    t_step_ctl         step_ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN_XOR;
            r_key  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                REG_CIPHER_MODE: r_mode <= t_cipher_mode'(i_cfg_wdata[0]);
                REG_KEY_WORD0:   r_key[0*KEY_WORD_W +: KEY_WORD_W] <= i_cfg_wdata;
                REG_KEY_WORD1:   r_key[1*KEY_WORD_W +: KEY_WORD_W] <= i_cfg_wdata;
                REG_KEY_WORD2:   r_key[2*KEY_WORD_W +: KEY_WORD_W] <= i_cfg_wdata;
                REG_KEY_WORD3:   r_key[3*KEY_WORD_W +: KEY_WORD_W] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow: the result register frees when empty or taken.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step_ctl.advance = r_in_valid && out_free;
    assign step_ctl.first   = r_in_first;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser[0];
        end
    end

    amxd_cipher_stage u_cipher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (step_ctl),
        .i_cipher_byte (r_in_byte),
        .i_mode        (r_mode),
        .i_key         (r_key),
        .o_plain_byte  (plain_byte)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_ctl.advance) begin
            r_out_byte <= plain_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;

    // Input is refused only when both stages hold an item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input refused with a free stage");

    // A stalled item in the input register keeps its contents.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_first)))
        else $error("stalled input item changed");

    // An advancing item always produces a result on the next cycle.
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_ctl.advance |=> r_out_valid)
        else $error("advanced item lost");

endmodule

// File: hdl/amxd_cipher_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cipher stage
// Holds the byte position and the four-byte feedback store, and forms the
// plain byte of the item that is advancing into the result register.
// ----------------------------------------------------------------------------
module amxd_cipher_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  amxd_pkg::t_step_ctl         i_ctl,
    input  logic [amxd_pkg::BYTE_W-1:0] i_cipher_byte,
    input  amxd_pkg::t_cipher_mode      i_mode,
    input  logic [amxd_pkg::KEY_W-1:0]  i_key,
    output logic [amxd_pkg::BYTE_W-1:0] o_plain_byte
);
    import amxd_pkg::*;

    logic [POS_W-1:0]  r_position;
    logic [POS_W-1:0]  n_position;
    logic [BYTE_W-1:0] r_feedback [FB_DEPTH];
    logic [BYTE_W-1:0] n_feedback [FB_DEPTH];
    logic [POS_W-1:0]  cur_pos;
    logic [SLOT_W-1:0] cur_slot;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] fb_byte;

    // A first item starts at position zero with the store reloaded from key word 0.
    assign cur_pos  = i_ctl.first ? '0 : r_position;
    assign cur_slot = cur_pos[SLOT_W-1:0];
    assign key_byte = i_key[cur_pos*BYTE_W +: BYTE_W];
    assign fb_byte  = i_ctl.first ? i_key[cur_slot*BYTE_W +: BYTE_W] : r_feedback[cur_slot];

    // Plain byte: key XOR, plus feedback XOR in feedback mode.
    always_comb begin
        o_plain_byte = i_cipher_byte ^ key_byte;
        if (i_mode == MODE_FEEDBACK) begin
            o_plain_byte = o_plain_byte ^ fb_byte;
        end
    end

    // Next position and feedback store.
    always_comb begin
        n_position = r_position;
        for (int i = 0; i < FB_DEPTH; i++) begin
            n_feedback[i] = r_feedback[i];
        end
        if (i_ctl.advance) begin
            if (i_ctl.first) begin
                for (int i = 0; i < FB_DEPTH; i++) begin
                    n_feedback[i] = i_key[i*BYTE_W +: BYTE_W];
                end
            end
            n_feedback[cur_slot] = i_cipher_byte;
            n_position           = cur_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            for (int i = 0; i < FB_DEPTH; i++) begin
                r_feedback[i] <= '0;
            end
        end else begin
            r_position <= n_position;
            for (int i = 0; i < FB_DEPTH; i++) begin
                r_feedback[i] <= n_feedback[i];
            end
        end
    end

    // A first item leaves the position at one.
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.advance && i_ctl.first) |=> (r_position == POS_W'(1)))
        else $error("position not restarted by first item");

    // Any other item moves the position on by one.
    a_step_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.advance && !i_ctl.first) |=> (r_position == $past(r_position) + POS_W'(1)))
        else $error("position did not advance by one");

    // The ciphertext byte lands in the slot it was decrypted against.
    a_fb_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.advance |=> (r_feedback[$past(cur_slot)] == $past(i_cipher_byte)))
        else $error("feedback slot not loaded with ciphertext");

    // Without a step the position holds.
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.advance |=> $stable(r_position))
        else $error("position moved without an item");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Archive member XOR decrypt core: self-checking bench
// Streams cipher bytes through the core under several mode and key settings.
// It predicts every plain byte with its own model of the key position and the
// feedback store, and checks each result in order. Both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
    import amxd_pkg::*;

    // Indexes past the last register; writes to them must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 4;
    localparam int RANDOM_ITEMS = 390;

    typedef struct packed {
        logic [7:0] cbyte;
        logic       first;
    } t_cipher_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data = '0;
    logic [0:0]             s_user = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_data;

    t_cipher_item  cipher_q[$];
    logic [7:0]    plain_expect_q[$];
    int            fail_count = 0;
    int unsigned   gap_left = 0;
    int unsigned   stall_left = 0;
    int            idle_cycles = 0;
    bit            src_steady = 1'b0;
    bit            snk_steady = 1'b0;

    // Model of the decryptor state and its registers
    t_cipher_mode  dec_mode = MODE_PLAIN_XOR;
    logic [31:0]   dec_key [4] = '{default: '0};
    logic [3:0]    dec_pos = '0;
    logic [7:0]    dec_fb [4] = '{default: '0};

    archive_member_xor_decrypt_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),   // [7:0] cipher_byte
        .i_s_axis_tuser (s_user),   // [0] first_byte
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)    // [7:0] plain_byte
    );

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Key byte at a position, taken little-endian from the key words.
    function automatic logic [7:0] member_key_byte(logic [3:0] idx);
        return dec_key[idx[3:2]][idx[1:0]*8 +: 8];
    endfunction

    // Decrypts one byte and advances the position and the feedback store.
    function automatic logic [7:0] decrypt_next(logic [7:0] cbyte, logic first);
        logic [3:0] pos;
        logic [1:0] slot;
        logic [7:0] plain;
        if (first) begin
            dec_pos = '0;
            for (int i = 0; i < FB_DEPTH; i++) begin
                dec_fb[i] = member_key_byte(4'(i));
            end
        end
        pos = dec_pos;
        slot = pos[1:0];
        plain = cbyte ^ member_key_byte(pos);
        if (dec_mode == MODE_FEEDBACK) begin
            plain = plain ^ dec_fb[slot];
        end
        dec_fb[slot] = cbyte;
        dec_pos = pos + 4'd1;
        return plain;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Register write; the model follows the same write.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_CIPHER_MODE: dec_mode = t_cipher_mode'(value[0]);
            REG_KEY_WORD0:   dec_key[0] = value;
            REG_KEY_WORD1:   dec_key[1] = value;
            REG_KEY_WORD2:   dec_key[2] = value;
            REG_KEY_WORD3:   dec_key[3] = value;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_byte(logic [7:0] cbyte, logic first);
        t_cipher_item it;
        it.cbyte = cbyte;
        it.first = first;
        cipher_q = {cipher_q, it};
    endtask

    // Waits until every item has been sent and every result has come back.
    task automatic wait_drained();
        while (cipher_q.size() != 0 || s_valid || plain_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return 32'h0000_0000;
        if (r < 4) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Source side: presents queued items, with random gaps between them.
    always @(posedge i_clk) begin : src_drive
        logic holding;
        t_cipher_item nxt;
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            s_user   <= '0;
            gap_left <= 0;
        end else begin
            holding = s_valid;
            if (s_valid && s_ready) begin
                plain_expect_q = {plain_expect_q, decrypt_next(s_data, s_user[0])};
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (cipher_q.size() != 0) begin
                    nxt = cipher_q.pop_front();
                    s_data   <= nxt.cbyte;
                    s_user   <= nxt.first;
                    s_valid  <= 1'b1;
                    gap_left <= src_steady ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each plain byte in order and stalls at random.
    always @(posedge i_clk) begin : result_check
        logic [7:0] want;
        if (!i_rst_n) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (plain_expect_q.size() == 0) begin
                    $error("plain_byte: unexpected result, actual %02h", m_data);
                    fail_count++;
                end else begin
                    want = plain_expect_q.pop_front();
                    if (m_data !== want) begin
                        $error("plain_byte: expected %02h, actual %02h", want, m_data);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                stall_left <= snk_steady ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed phases, then random members under random settings.
    initial begin : stimulus
        logic [7:0] edge_bytes [16];
        int sent;
        int len;
        int unsigned r;
        edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA, 8'h55,
                       8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h12, 8'hED, 8'h69, 8'h96};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Feedback mode with no first byte since reset: zero store, position 0.
        write_reg(REG_CIPHER_MODE, 32'd1);
        write_reg(REG_KEY_WORD1, 32'hA5C3_0F81);
        for (int i = 0; i < 5; i++) push_byte(edge_bytes[i], 1'b0);
        wait_drained();

        // Plain mode, extreme keys, ignored spare indexes, wrap past byte 15.
        write_reg(REG_CIPHER_MODE, 32'd0);
        write_reg(REG_KEY_WORD0, 32'hFFFF_FFFF);
        write_reg(REG_KEY_WORD1, 32'h0000_0000);
        write_reg(REG_KEY_WORD2, 32'h8000_0001);
        write_reg(REG_KEY_WORD3, 32'h7F3C_5AA5);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        push_byte(8'h00, 1'b1);
        for (int i = 1; i < 16; i++) push_byte(edge_bytes[i], 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // Mode and key change inside a member keep the position and the store.
        write_reg(REG_CIPHER_MODE, 32'd1);
        write_reg(REG_KEY_WORD0, 32'h1234_5678);
        for (int i = 0; i < 4; i++) push_byte(edge_bytes[15 - i], 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_drained();

        // Random phases: mostly well-formed members, some broken sequences.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_reg(REG_CIPHER_MODE, 32'($urandom_range(0, 1)));
            write_reg(REG_KEY_WORD0, pick_key_word());
            write_reg(REG_KEY_WORD1, pick_key_word());
            write_reg(REG_KEY_WORD2, pick_key_word());
            write_reg(REG_KEY_WORD3, pick_key_word());
            if ($urandom_range(0, 3) == 0) begin
                write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            end
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            for (int p = 0; p < 50; ) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    len = $urandom_range(1, 40);
                    for (int i = 0; i < len; i++) begin
                        push_byte(8'($urandom_range(0, 255)), i == 0);
                    end
                end else if (r < 9) begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++) begin
                        push_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                end else begin
                    len = 1;
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                p += len;
                sent += len;
            end
            wait_drained();
        end

        if (fail_count == 0 && plain_expect_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
